// ===== design/tmt_pkg.sv =====
`timescale 1ns / 1ps

package tmt_pkg;

  localparam int unsigned ID_W        = 8;
  localparam int unsigned TAG_W       = 8;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned CNT_OUT_W   = 5;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned STATUS_W    = 2;

  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Cap on fired results per tick; further due entries wait for the next tick.
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned FIRE_CNT_W   = $clog2(RESULT_LIMIT + 1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_ACK  = 2'd0,
    KIND_FIRED    = 2'd1,
    KIND_CTRL_ACK = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK   = 2'd0,
    STS_DUP  = 2'd1,
    STS_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   event_id;
    logic [TIME_W-1:0] timeout_ms;
    logic              one_shot;
    logic [TAG_W-1:0]  handler_tag;
    logic [TIME_W-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    kind_e                kind;
    status_e              status;
    logic [ID_W-1:0]      fired_id;
    logic [TAG_W-1:0]     fired_tag;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 last;
  } res_t;

endpackage

// ===== design/tmt_front.sv =====
`timescale 1ns / 1ps

module tmt_front import tmt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [CAP_W-1:0]                       cfg_wdata_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]                  s_axis_tdata,
  input  logic [OP_W-1:0]                        s_axis_tuser,
  input  logic                                   q_full_i,
  output logic                                   q_push_o,
  output cmd_t                                   q_cmd_o,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]       eff_cap_o
);

  localparam int unsigned VW = $clog2(MAX_ENTRIES + 1);

  logic [CAP_W-1:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // zero behaves as one, anything above the table size as the table size
  always_comb begin
    if (cap_q == '0) begin
      eff_cap_o = VW'(1);
    end else if (32'(cap_q) > MAX_ENTRIES) begin
      eff_cap_o = VW'(MAX_ENTRIES);
    end else begin
      eff_cap_o = VW'(cap_q);
    end
  end

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_cmd_o.op          = op_e'(s_axis_tuser);
    q_cmd_o.event_id    = s_axis_tdata[7:0];
    q_cmd_o.timeout_ms  = s_axis_tdata[39:8];
    q_cmd_o.one_shot    = s_axis_tdata[40];
    q_cmd_o.handler_tag = s_axis_tdata[48:41];
    q_cmd_o.now_ms      = s_axis_tdata[80:49];
  end

endmodule

// ===== design/tmt_queue.sv =====
`timescale 1ns / 1ps

module tmt_queue import tmt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t              buf_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = buf_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wr_ptr_q] <= cmd_i;
  end

endmodule

// ===== design/tmt_back.sv =====
`timescale 1ns / 1ps

module tmt_back import tmt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]   eff_cap_i,
  input  logic                               q_valid_i,
  input  cmd_t                               q_cmd_i,
  output logic                               q_pop_o,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output res_t                               res_o
);

  localparam int unsigned VW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW = VW;
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // entry store, one array per field, read port registered
  logic [ID_W-1:0]   id_mem      [MAX_ENTRIES];
  logic [TAG_W-1:0]  tag_mem     [MAX_ENTRIES];
  logic [TIME_W-1:0] timeout_mem [MAX_ENTRIES];
  logic [TIME_W-1:0] stamp_mem   [MAX_ENTRIES];
  logic              shot_mem    [MAX_ENTRIES];

  logic [ID_W-1:0]   rd_id_q;
  logic [TAG_W-1:0]  rd_tag_q;
  logic [TIME_W-1:0] rd_timeout_q;
  logic [TIME_W-1:0] rd_stamp_q;
  logic              rd_shot_q;

  state_e                 state_q, state_d;
  logic [CW-1:0]          rd_cnt_q, rd_cnt_d;
  logic                   s1_vld_q, s1_vld_d;
  logic [IW-1:0]          s1_idx_q, s1_idx_d;
  logic                   dup_q, dup_d;
  logic                   found_q, found_d;
  logic [IW-1:0]          free_idx_q, free_idx_d;
  logic                   full_q, full_d;
  logic [FIRE_CNT_W-1:0]  fc_q, fc_d;
  logic                   pend_q, pend_d;
  logic [ID_W-1:0]        pend_id_q, pend_id_d;
  logic [TAG_W-1:0]       pend_tag_q, pend_tag_d;
  logic [CNT_OUT_W-1:0]   pend_cnt_q, pend_cnt_d;
  logic                   running_q, running_d;
  logic [MAX_ENTRIES-1:0] entry_valid_q, entry_valid_d;
  logic [VW-1:0]          vcnt_q, vcnt_d;
  cmd_t                   cmd_q;

  logic                   out_vld_q;
  res_t                   out_q;
  res_t                   out_res;
  logic                   out_load, out_free;

  logic [IW-1:0]          rd_idx;
  logic                   issue, rd_en, stall;
  logic                   ent_vld, fire, add_ok;
  logic [TIME_W:0]        due;
  logic                   ent_we, stamp_we;
  logic [IW-1:0]          stamp_waddr;
  logic [TIME_W-1:0]      stamp_wdata;

  assign rd_idx   = rd_cnt_q[IW-1:0];
  assign out_free = !out_vld_q || res_ready_i;
  assign ent_vld  = entry_valid_q[s1_idx_q];
  // 33-bit sum, no wrap
  assign due      = {1'b0, rd_timeout_q} + {1'b0, rd_stamp_q};
  assign fire     = s1_vld_q && (cmd_q.op == OP_TICK) && ent_vld &&
                    ({1'b0, cmd_q.now_ms} > due) &&
                    (fc_q < FIRE_CNT_W'(RESULT_LIMIT));
  assign add_ok   = !full_q && !dup_q;

  always_comb begin
    state_d       = state_q;
    rd_cnt_d      = rd_cnt_q;
    s1_vld_d      = s1_vld_q;
    s1_idx_d      = s1_idx_q;
    dup_d         = dup_q;
    found_d       = found_q;
    free_idx_d    = free_idx_q;
    full_d        = full_q;
    fc_d          = fc_q;
    pend_d        = pend_q;
    pend_id_d     = pend_id_q;
    pend_tag_d    = pend_tag_q;
    pend_cnt_d    = pend_cnt_q;
    running_d     = running_q;
    entry_valid_d = entry_valid_q;
    vcnt_d        = vcnt_q;
    q_pop_o       = 1'b0;
    issue         = 1'b0;
    rd_en         = 1'b0;
    stall         = 1'b0;
    ent_we        = 1'b0;
    stamp_we      = 1'b0;
    stamp_waddr   = s1_idx_q;
    stamp_wdata   = cmd_q.now_ms;
    out_load      = 1'b0;
    out_res.kind        = KIND_FIRED;
    out_res.status      = STS_OK;
    out_res.fired_id    = pend_id_q;
    out_res.fired_tag   = pend_tag_q;
    out_res.entry_count = pend_cnt_q;
    out_res.last        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          rd_cnt_d = '0;
          s1_vld_d = 1'b0;
          dup_d    = 1'b0;
          found_d  = 1'b0;
          full_d   = 1'b0;
          fc_d     = '0;
          pend_d   = 1'b0;
          unique case (q_cmd_i.op)
            OP_ADD: begin
              // full wins over duplicate
              if (vcnt_q >= eff_cap_i) begin
                full_d  = 1'b1;
                state_d = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_START: state_d = S_SCAN;
            OP_STOP:  state_d = S_DONE;
            OP_TICK:  state_d = running_q ? S_SCAN : S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        issue = (rd_cnt_q != CW'(MAX_ENTRIES));
        if (s1_vld_q) begin
          unique case (cmd_q.op)
            OP_ADD: begin
              if (ent_vld && (rd_id_q == cmd_q.event_id)) dup_d = 1'b1;
              if (!ent_vld && !found_q) begin
                found_d    = 1'b1;
                free_idx_d = s1_idx_q;
              end
            end
            OP_START: begin
              if (ent_vld) stamp_we = 1'b1;
            end
            OP_TICK: begin
              if (fire) begin
                if (pend_q && !out_free) begin
                  stall = 1'b1;
                end else begin
                  // previous fire is not the last one: send it now
                  out_load   = pend_q;
                  pend_d     = 1'b1;
                  pend_id_d  = rd_id_q;
                  pend_tag_d = rd_tag_q;
                  fc_d       = fc_q + 1'b1;
                  if (rd_shot_q) begin
                    entry_valid_d[s1_idx_q] = 1'b0;
                    vcnt_d     = vcnt_q - 1'b1;
                    pend_cnt_d = CNT_OUT_W'(vcnt_q - 1'b1);
                  end else begin
                    stamp_we   = 1'b1;
                    pend_cnt_d = CNT_OUT_W'(vcnt_q);
                  end
                end
              end
            end
            default: ;
          endcase
        end
        if (!stall) begin
          rd_en    = issue;
          s1_vld_d = issue;
          s1_idx_d = rd_idx;
          if (issue) rd_cnt_d = rd_cnt_q + 1'b1;
          if (!issue && !s1_vld_q) state_d = S_DONE;
        end
      end

      S_DONE: begin
        out_res.fired_id    = '0;
        out_res.fired_tag   = '0;
        out_res.entry_count = CNT_OUT_W'(vcnt_q);
        out_res.last        = 1'b1;
        unique case (cmd_q.op)
          OP_ADD: begin
            out_res.kind = KIND_ADD_ACK;
            if (full_q) begin
              out_res.status = STS_FULL;
            end else if (dup_q) begin
              out_res.status = STS_DUP;
            end else begin
              out_res.status      = STS_OK;
              out_res.entry_count = CNT_OUT_W'(vcnt_q + 1'b1);
            end
            if (out_free) begin
              out_load = 1'b1;
              state_d  = S_IDLE;
              if (add_ok) begin
                ent_we        = 1'b1;
                stamp_we      = 1'b1;
                stamp_waddr   = free_idx_q;
                stamp_wdata   = '0;
                entry_valid_d[free_idx_q] = 1'b1;
                vcnt_d        = vcnt_q + 1'b1;
              end
            end
          end
          OP_START, OP_STOP: begin
            out_res.kind = KIND_CTRL_ACK;
            if (out_free) begin
              out_load  = 1'b1;
              running_d = (cmd_q.op == OP_START);
              state_d   = S_IDLE;
            end
          end
          OP_TICK: begin
            out_res.kind        = KIND_FIRED;
            out_res.fired_id    = pend_id_q;
            out_res.fired_tag   = pend_tag_q;
            out_res.entry_count = pend_cnt_q;
            if (!pend_q) begin
              state_d = S_IDLE;
            end else if (out_free) begin
              out_load = 1'b1;
              state_d  = S_IDLE;
            end
          end
        endcase
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      rd_cnt_q      <= '0;
      s1_vld_q      <= 1'b0;
      s1_idx_q      <= '0;
      dup_q         <= 1'b0;
      found_q       <= 1'b0;
      full_q        <= 1'b0;
      fc_q          <= '0;
      pend_q        <= 1'b0;
      running_q     <= 1'b0;
      entry_valid_q <= '0;
      vcnt_q        <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      rd_cnt_q      <= rd_cnt_d;
      s1_vld_q      <= s1_vld_d;
      s1_idx_q      <= s1_idx_d;
      dup_q         <= dup_d;
      found_q       <= found_d;
      full_q        <= full_d;
      fc_q          <= fc_d;
      pend_q        <= pend_d;
      running_q     <= running_d;
      entry_valid_q <= entry_valid_d;
      vcnt_q        <= vcnt_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cmd_q <= q_cmd_i;
    free_idx_q <= free_idx_d;
    pend_id_q  <= pend_id_d;
    pend_tag_q <= pend_tag_d;
    pend_cnt_q <= pend_cnt_d;
    if (out_load) out_q <= out_res;
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      id_mem[free_idx_q]      <= cmd_q.event_id;
      tag_mem[free_idx_q]     <= cmd_q.handler_tag;
      timeout_mem[free_idx_q] <= cmd_q.timeout_ms;
      shot_mem[free_idx_q]    <= cmd_q.one_shot;
    end
    if (stamp_we) stamp_mem[stamp_waddr] <= stamp_wdata;
    if (rd_en) begin
      rd_id_q      <= id_mem[rd_idx];
      rd_tag_q     <= tag_mem[rd_idx];
      rd_timeout_q <= timeout_mem[rd_idx];
      rd_stamp_q   <= stamp_mem[rd_idx];
      rd_shot_q    <= shot_mem[rd_idx];
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

`ifndef SYNTH
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(entry_valid_q) == 32'(vcnt_q))
    else $error("valid count out of step with valid bits");

  a_stall_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> (pend_q && out_vld_q && !res_ready_i))
    else $error("scan stalled without a held result");

  a_fired_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.kind == KIND_FIRED) |-> (out_q.status == STS_OK))
    else $error("fired result with nonzero status");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(rd_cnt_q) <= MAX_ENTRIES)
    else $error("scan counter past table end");

  a_fire_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fc_q) <= RESULT_LIMIT)
    else $error("too many fires in one tick");
`endif

endmodule

// ===== design/periodic_oneshot_timer_table.sv =====
`timescale 1ns / 1ps
// Timer table: add, start, stop and tick transactions pass a 2-deep command queue.
// Add (not full), start and running tick scan all MAX_ENTRIES slots through the registered
// memory read; output stalls can hold the scan; up to 16 fires per tick. Stop and full add
// skip the scan; a stopped tick gives no result. Each transaction finishes before the next.
// Async active-low reset clears valid bits, entry count, running flag and queue, and
// sets capacity to 16; entry memory is not cleared (no clearing pass).

module periodic_oneshot_timer_table import tmt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CAP_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // event_id[7:0], timeout_ms[39:8], one_shot[40], handler_tag[48:41], now_ms[80:49]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [OP_W-1:0]        s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status[1:0], fired_id[9:2], fired_tag[17:10], entry_count[22:18]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // kind[1:0]
  output logic [KIND_W-1:0]      m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int unsigned VW = $clog2(MAX_ENTRIES + 1);

  logic          q_full, q_push, q_valid, q_pop;
  cmd_t          push_cmd, head_cmd;
  logic [VW-1:0] eff_cap;
  res_t          res;

  tmt_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (push_cmd),
    .eff_cap_o     (eff_cap)
  );

  tmt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  tmt_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_cap_i   (eff_cap),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {1'b0, res.entry_count, res.fired_tag, res.fired_id, res.status};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// ===== tb/timer_table_checker.sv =====
`timescale 1ns / 1ps

module timer_table_checker import tmt_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CAP_W-1:0]       cfg_wdata_i,
  input  logic                   cmd_valid_i,
  input  logic                   cmd_ready_i,
  // event_id, timeout_ms, one_shot, handler_tag, now_ms
  input  logic [IN_TDATA_W-1:0]  cmd_data_i,
  // op
  input  logic [OP_W-1:0]        cmd_op_i,
  input  logic                   res_valid_i,
  input  logic                   res_ready_i,
  // status, fired_id, fired_tag, entry_count
  input  logic [OUT_TDATA_W-1:0] res_data_i,
  // kind
  input  logic [KIND_W-1:0]      res_kind_i,
  input  logic                   res_last_i,
  output int unsigned            errors_o,
  output int unsigned            awaited_o,
  output int unsigned            results_o,
  output int unsigned            expiries_o,
  output int unsigned            rejects_o
);

  logic                 slot_used    [SLOTS];
  logic [ID_W-1:0]      slot_id      [SLOTS];
  logic [TIME_W-1:0]    slot_timeout [SLOTS];
  logic [TIME_W-1:0]    slot_stamp   [SLOTS];
  logic                 slot_once    [SLOTS];
  logic [TAG_W-1:0]     slot_tag     [SLOTS];
  logic                 running;
  logic [CNT_OUT_W-1:0] live_count;
  logic [CAP_W-1:0]     capacity;

  res_t        awaited_results[$];
  int unsigned errors   = 0;
  int unsigned results  = 0;
  int unsigned expiries = 0;
  int unsigned rejects  = 0;

  function automatic res_t make_result(kind_e kind, status_e status, logic [ID_W-1:0] id,
                                       logic [TAG_W-1:0] tag, logic last);
    res_t r;
    r.kind        = kind;
    r.status      = status;
    r.fired_id    = id;
    r.fired_tag   = tag;
    r.entry_count = live_count;
    r.last        = last;
    return r;
  endfunction

  // 0 behaves as 1, anything above the table size as the table size
  function automatic int unsigned usable_slots();
    if (capacity == '0) return 1;
    if (32'(capacity) > SLOTS) return SLOTS;
    return 32'(capacity);
  endfunction

  task automatic apply_timer_cmd(input op_e op, input logic [ID_W-1:0] id,
                                 input logic [TIME_W-1:0] tmo, input logic once,
                                 input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] now);
    status_e       status;
    logic          placed;
    logic          have_held;
    res_t          held;
    logic [TIME_W:0] due;
    int unsigned   fired;
    status    = STS_OK;
    placed    = 1'b0;
    have_held = 1'b0;
    held      = '0;
    fired     = 0;
    case (op)
      OP_ADD: begin
        // a full table is reported before any duplicate check
        if (32'(live_count) >= usable_slots()) begin
          status = STS_FULL;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_id[i] == id) status = STS_DUP;
          end
        end
        if (status == STS_OK) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[i] && !placed) begin
              slot_used[i]    = 1'b1;
              slot_id[i]      = id;
              slot_timeout[i] = tmo;
              slot_stamp[i]   = '0;
              slot_once[i]    = once;
              slot_tag[i]     = tag;
              live_count      = live_count + 1'b1;
              placed          = 1'b1;
            end
          end
        end else begin
          rejects++;
        end
        awaited_results.push_back(make_result(KIND_ADD_ACK, status, '0, '0, 1'b1));
      end
      OP_START: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i]) slot_stamp[i] = now;
        end
        running = 1'b1;
        awaited_results.push_back(make_result(KIND_CTRL_ACK, STS_OK, '0, '0, 1'b1));
      end
      OP_STOP: begin
        running = 1'b0;
        awaited_results.push_back(make_result(KIND_CTRL_ACK, STS_OK, '0, '0, 1'b1));
      end
      default: begin
        if (running) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && fired < RESULT_LIMIT) begin
              due = {1'b0, slot_timeout[i]} + {1'b0, slot_stamp[i]};
              if ({1'b0, now} > due) begin
                if (slot_once[i]) begin
                  slot_used[i] = 1'b0;
                  live_count   = live_count - 1'b1;
                end else begin
                  slot_stamp[i] = now;
                end
                // hold each fire back one step so the final one can carry last
                if (have_held) awaited_results.push_back(held);
                held      = make_result(KIND_FIRED, STS_OK, slot_id[i], slot_tag[i], 1'b0);
                have_held = 1'b1;
                fired++;
              end
            end
          end
          if (have_held) begin
            held.last = 1'b1;
            awaited_results.push_back(held);
          end
          expiries += fired;
        end
      end
    endcase
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got.kind        = kind_e'(res_kind_i);
    got.status      = status_e'(res_data_i[1:0]);
    got.fired_id    = res_data_i[9:2];
    got.fired_tag   = res_data_i[17:10];
    got.entry_count = res_data_i[22:18];
    got.last        = res_last_i;
    results++;
    if (awaited_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result with none awaited: kind %0d status %0d id %02h tag %02h count %0d last %0b",
                 $time, got.kind, got.status, got.fired_id, got.fired_tag,
                 got.entry_count, got.last);
    end else begin
      want = awaited_results.pop_front();
      if (got.kind !== want.kind || got.status !== want.status ||
          got.fired_id !== want.fired_id || got.fired_tag !== want.fired_tag ||
          got.entry_count !== want.entry_count || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result mismatch (expected / actual)", $time);
          $display("  kind %0d / %0d  status %0d / %0d  id %02h / %02h  tag %02h / %02h",
                   want.kind, got.kind, want.status, got.status,
                   want.fired_id, got.fired_id, want.fired_tag, got.fired_tag);
          $display("  count %0d / %0d  last %0b / %0b",
                   want.entry_count, got.entry_count, want.last, got.last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i]    = 1'b0;
        slot_id[i]      = '0;
        slot_timeout[i] = '0;
        slot_stamp[i]   = '0;
        slot_once[i]    = 1'b0;
        slot_tag[i]     = '0;
      end
      running    = 1'b0;
      live_count = '0;
      capacity   = CAP_RESET;
      awaited_results.delete();
    end else begin
      // a result accepted now always belongs to an earlier command
      if (res_valid_i && res_ready_i) check_result();
      if (cmd_valid_i && cmd_ready_i)
        apply_timer_cmd(op_e'(cmd_op_i), cmd_data_i[7:0], cmd_data_i[39:8], cmd_data_i[40],
                        cmd_data_i[48:41], cmd_data_i[80:49]);
      if (cfg_we_i) capacity = cfg_wdata_i;
    end
    errors_o   <= errors;
    awaited_o  <= awaited_results.size();
    results_o  <= results;
    expiries_o <= expiries;
    rejects_o  <= rejects;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tmt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned PHASES       = 10;
  // capacity per random phase, phase 0 in the lowest bits
  localparam logic [PHASES*CAP_W-1:0] CAP_PLAN = {5'd16, 5'd3, 5'd8, 5'd4, 5'd17,
                                                  5'd16, 5'd2, 5'd31, 5'd0, 5'd1};

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CAP_W-1:0]       cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]      m_axis_tuser;
  logic                   m_axis_tlast;

  int unsigned errors, awaited, results, expiries, rejects;
  int unsigned cycles     = 0;
  int unsigned gap_odds   = 0;
  int unsigned stall_odds = 0;
  int unsigned stall_left = 0;
  int unsigned sent       = 0;
  int unsigned cap_writes = 0;
  logic [TIME_W-1:0] clock_ms;

  periodic_oneshot_timer_table #(.MAX_ENTRIES(16)) dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  timer_table_checker #(.SLOTS(16)) u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_i (s_axis_tready),
    .cmd_data_i  (s_axis_tdata),
    .cmd_op_i    (s_axis_tuser),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .res_kind_i  (m_axis_tuser),
    .res_last_i  (m_axis_tlast),
    .errors_o    (errors),
    .awaited_o   (awaited),
    .results_o   (results),
    .expiries_o  (expiries),
    .rejects_o   (rejects)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("== FAIL ==");
    $finish;
  end

  // result-side backpressure in bursts
  always @(posedge clk_i) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left    <= 0;
      m_axis_tready <= 1'b1;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left    <= $urandom_range(1, 5);
      m_axis_tready <= 1'b0;
    end
  end

  task automatic send_cmd(input op_e op, input logic [ID_W-1:0] id, input logic [TIME_W-1:0] tmo,
                          input logic once, input logic [TAG_W-1:0] tag,
                          input logic [TIME_W-1:0] now);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, now, tag, once, tmo, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  // wait out every awaited result, then the scan of any tick that yields nothing
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_writes++;
  endtask

  // mostly adds and advancing ticks against a phase clock, plus random-time noise
  task automatic random_cmd();
    int unsigned       pick;
    int unsigned       r;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tmo;
    logic              once;
    logic [TAG_W-1:0]  tag;
    pick = $urandom_range(0, 99);
    r    = $urandom_range(0, 19);
    id   = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 31));
    tmo  = (r == 0) ? $urandom : (r < 3) ? 32'd0 : 32'($urandom_range(0, 60));
    once = ($urandom_range(0, 5) != 0);
    tag  = 8'($urandom_range(0, 255));
    if (pick < 30) begin
      send_cmd(OP_ADD, id, tmo, once, tag, $urandom);
    end else if (pick < 38) begin
      send_cmd(OP_START, id, tmo, once, tag, clock_ms);
    end else if (pick < 43) begin
      send_cmd(OP_STOP, id, tmo, once, tag, $urandom);
    end else if (pick < 46) begin
      send_cmd(OP_TICK, id, tmo, once, tag, $urandom);
    end else begin
      clock_ms = clock_ms + $urandom_range(0, 25);
      send_cmd(OP_TICK, id, tmo, once, tag, clock_ms);
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_odds = 4;
    stall_odds <= 4;
    // tick while stopped, then stop while stopped
    send_cmd(OP_TICK, 8'h00, 32'h0000_0000, 1'b0, 8'h00, 32'd100);
    send_cmd(OP_STOP, 8'h5A, 32'hA5A5_A5A5, 1'b1, 8'hC3, 32'h0000_0000);
    send_cmd(OP_ADD, 8'h00, 32'h0000_0000, 1'b1, 8'h00, 32'hFFFF_FFFF);
    send_cmd(OP_ADD, 8'hFF, 32'hFFFF_FFF0, 1'b0, 8'hFF, 32'h0000_0000);
    send_cmd(OP_ADD, 8'h00, 32'd5, 1'b0, 8'h11, 32'h0000_0000);
    for (int n = 1; n <= 14; n++)
      send_cmd(OP_ADD, 8'(n), 32'd0, 1'b1, 8'($urandom_range(0, 255)), $urandom);
    // table full with a duplicate id: full wins
    send_cmd(OP_ADD, 8'h00, 32'd7, 1'b0, 8'h22, 32'h0000_0000);
    send_cmd(OP_START, 8'h00, 32'h0000_0000, 1'b0, 8'h00, 32'h0000_0000);
    // all sixteen entries fire at once
    send_cmd(OP_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 32'hFFFF_FFFF);
    // restamped entry is due past 2^32, must not fire on a wrapped sum
    send_cmd(OP_TICK, 8'h00, 32'h0000_0000, 1'b0, 8'h00, 32'hFFFF_FFFF);
    send_cmd(OP_START, 8'h00, 32'h0000_0000, 1'b0, 8'h00, 32'd5);
    send_cmd(OP_STOP, 8'h00, 32'h0000_0000, 1'b0, 8'h00, 32'h0000_0000);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      set_capacity(CAP_PLAN[phase*CAP_W +: CAP_W]);
      if (phase == PHASES - 1) begin
        gap_odds = 0;
        stall_odds <= 0;
      end else if (phase % 3 == 1) begin
        gap_odds = 0;
        stall_odds <= 3;
      end else if (phase % 3 == 2) begin
        gap_odds = 3;
        stall_odds <= 0;
      end else begin
        gap_odds = 4;
        stall_odds <= 4;
      end
      clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : 32'($urandom_range(0, 100000));
      send_cmd(OP_START, 8'($urandom_range(0, 255)), $urandom, 1'b0, 8'h00, clock_ms);
      repeat (29) random_cmd();
    end
    drain_results();

    $display("covered %0d commands over %0d capacity settings, %0d results checked",
             sent, cap_writes, results);
    $display("entry expiries: %0d, rejected adds: %0d", expiries, rejects);
    if (errors == 0 && awaited == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, awaited);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tmt_pkg.sv
design/tmt_front.sv
design/tmt_queue.sv
design/tmt_back.sv
design/periodic_oneshot_timer_table.sv
tb/timer_table_checker.sv
tb/tb.sv
